// ===== rtl/core/icrt_pkg.sv =====
// icrt_pkg: shared constants, types and structs for the integer to radix text block
// no dependencies; used by every module under rtl/core

package icrt_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int VALUE_BITS  = 32;
    localparam int SYM_W       = 8;
    localparam int CFG_W       = 64;
    localparam int RADIX_W     = 5;
    localparam int CFG_IDX_W   = 2;

    localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
    localparam int REM_W       = DIGIT_W + 1;
    localparam int DIV_STEPS   = 8;
    localparam int DIV_CYCLES  = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W       = DIV_CYCLES * DIV_STEPS;
    localparam int DIV_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int CNT_W       = $clog2(VALUE_BITS + 1);

    typedef logic [SYM_W-1:0]      sym_t;
    typedef logic [VALUE_BITS-1:0] word_t;
    typedef logic [DIGIT_W-1:0]    digit_t;
    typedef logic [REM_W-1:0]      rem_t;
    typedef logic [RADIX_W-1:0]    radix_t;
    typedef logic [DIV_W-1:0]      divw_t;
    typedef logic [DIV_CNT_W-1:0]  divcnt_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef logic [MAX_SYMBOLS-1:0][SYM_W-1:0] sym_array_t;

    localparam sym_t   CH_PLUS   = 8'h2B;
    localparam sym_t   CH_MINUS  = 8'h2D;
    localparam sym_t   CH_NUL    = 8'h00;
    localparam radix_t MIN_RADIX = 5'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIX_SIZE   = 2'd0,
        REG_SYMBOLS_LOW  = 2'd1,
        REG_SYMBOLS_HIGH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
    } div_req_t;

    typedef struct packed {
        logic   done;
        word_t  quotient;
        digit_t remainder;
    } div_rsp_t;

endpackage

// ===== rtl/core/icrt_alpha_check.sv =====
// icrt_alpha_check: validity check of the configured symbol alphabet
// depends on icrt_pkg

module icrt_alpha_check (
    input  icrt_pkg::radix_t     radix_size,
    input  icrt_pkg::sym_array_t syms,
    output logic                 ok
);

    always_comb
    begin
        ok = (radix_size >= icrt_pkg::MIN_RADIX) &&
             (radix_size <= icrt_pkg::radix_t'(icrt_pkg::MAX_SYMBOLS));
        for (int i = 0; i < icrt_pkg::MAX_SYMBOLS; i++)
        begin
            if (icrt_pkg::radix_t'(i) < radix_size)
            begin
                if ((syms[i] == icrt_pkg::CH_NUL) || (syms[i] == icrt_pkg::CH_PLUS) ||
                    (syms[i] == icrt_pkg::CH_MINUS))
                begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < icrt_pkg::MAX_SYMBOLS; j++)
                begin
                    if ((icrt_pkg::radix_t'(j) < radix_size) && (syms[j] == syms[i]))
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/icrt_divider.sv =====
// icrt_divider: shared restoring divider, word by small radix, eight quotient bits a cycle
// depends on icrt_pkg

module icrt_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  icrt_pkg::div_req_t req,
    input  icrt_pkg::rem_t     radix,
    output icrt_pkg::div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    icrt_pkg::divcnt_t cnt_reg, cnt_next;
    icrt_pkg::divw_t   q_reg, q_next;
    icrt_pkg::digit_t  r_reg, r_next;

    icrt_pkg::divw_t   q_work;
    icrt_pkg::digit_t  r_work;
    icrt_pkg::rem_t    trial;

    // one row of the long division per step, msb first
    always_comb
    begin
        q_work = q_reg;
        r_work = r_reg;
        trial  = '0;
        for (int k = 0; k < icrt_pkg::DIV_STEPS; k++)
        begin
            trial  = {r_work, q_work[icrt_pkg::DIV_W-1]};
            q_work = {q_work[icrt_pkg::DIV_W-2:0], 1'b0};
            if (trial >= radix)
            begin
                r_work    = icrt_pkg::digit_t'(trial - radix);
                q_work[0] = 1'b1;
            end
            else
            begin
                r_work = trial[icrt_pkg::DIGIT_W-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = icrt_pkg::divw_t'(req.dividend);
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            q_next   = q_work;
            r_next   = r_work;
            cnt_next = cnt_reg + icrt_pkg::divcnt_t'(1);
            if (cnt_reg == icrt_pkg::divcnt_t'(icrt_pkg::DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg[icrt_pkg::VALUE_BITS-1:0];
    assign rsp.remainder = r_reg;

    a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

// ===== rtl/core/integer_to_custom_radix_text_top.sv =====
// integer_to_custom_radix_text_top: configuration registers, digit stack and sequencer
// each digit is one division in the shared divider followed by a hand-over to the digit stack, and the
// first character appears once all digits are on the stack; then one a cycle while out_ready is high
// one value at a time: a new value is taken only once the last character has gone
// an invalid alphabet drops the value with no output
// reset: configuration clears to zero (alphabet invalid), sequencer returns to idle

module integer_to_custom_radix_text_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [icrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [icrt_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [31:0]                  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          character,
    output logic                                last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    icrt_pkg::radix_t              radix_size_reg, radix_size_next;
    logic [icrt_pkg::CFG_W-1:0]    symbols_low_reg, symbols_low_next;
    logic [icrt_pkg::CFG_W-1:0]    symbols_high_reg, symbols_high_next;

    state_t                        state_reg, state_next;
    logic                          neg_reg, neg_next;
    icrt_pkg::cnt_t                nd_reg, nd_next;
    icrt_pkg::digit_t [icrt_pkg::VALUE_BITS-1:0] stack_reg, stack_next;

    logic [2*icrt_pkg::CFG_W-1:0]  sym_flat;
    icrt_pkg::sym_array_t          syms;
    logic                          alpha_ok;
    icrt_pkg::word_t               v;
    logic                          v_neg;
    icrt_pkg::word_t               mag;
    icrt_pkg::cnt_t                nd_inc;
    icrt_pkg::div_req_t            div_req;
    icrt_pkg::div_rsp_t            div_rsp;

    assign sym_flat = {symbols_high_reg, symbols_low_reg};
    assign syms     = sym_flat[icrt_pkg::MAX_SYMBOLS*icrt_pkg::SYM_W-1:0];

    icrt_alpha_check u_alpha_check (
        .radix_size (radix_size_reg),
        .syms       (syms),
        .ok         (alpha_ok)
    );

    icrt_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .radix (radix_size_reg[icrt_pkg::REM_W-1:0]),
        .rsp   (div_rsp)
    );

    // configuration writes
    always_comb
    begin
        radix_size_next   = radix_size_reg;
        symbols_low_next  = symbols_low_reg;
        symbols_high_next = symbols_high_reg;
        if (cfg_we)
        begin
            case (icrt_pkg::cfg_reg_t'(cfg_index))
                icrt_pkg::REG_RADIX_SIZE:   radix_size_next   = cfg_data[icrt_pkg::RADIX_W-1:0];
                icrt_pkg::REG_SYMBOLS_LOW:  symbols_low_next  = cfg_data;
                icrt_pkg::REG_SYMBOLS_HIGH: symbols_high_next = cfg_data;
                default:                    radix_size_next   = radix_size_reg;
            endcase
        end
    end

    // magnitude without overflow, the most negative value maps onto itself
    assign v      = value[icrt_pkg::VALUE_BITS-1:0];
    assign v_neg  = v[icrt_pkg::VALUE_BITS-1];
    assign mag    = v_neg ? icrt_pkg::word_t'(~v + 1'b1) : v;
    assign nd_inc = nd_reg + icrt_pkg::cnt_t'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_SIGN) || (state_reg == S_EMIT);
    assign character = (state_reg == S_SIGN) ? icrt_pkg::CH_MINUS : syms[stack_reg[0]];
    assign last      = (state_reg == S_EMIT) && (nd_reg == icrt_pkg::cnt_t'(1));

    always_comb
    begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        nd_next          = nd_reg;
        stack_next       = stack_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mag;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && alpha_ok)
                begin
                    neg_next      = v_neg;
                    nd_next       = '0;
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    // push: newest digit on top is the most significant so far
                    for (int i = icrt_pkg::VALUE_BITS - 1; i > 0; i--)
                    begin
                        stack_next[i] = stack_reg[i-1];
                    end
                    stack_next[0] = div_rsp.remainder;
                    nd_next       = nd_inc;
                    if ((div_rsp.quotient != '0) &&
                        (nd_inc < icrt_pkg::cnt_t'(icrt_pkg::VALUE_BITS)))
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                    end
                    else
                    begin
                        state_next = neg_reg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    for (int i = 0; i < icrt_pkg::VALUE_BITS - 1; i++)
                    begin
                        stack_next[i] = stack_reg[i+1];
                    end
                    nd_next = nd_reg - icrt_pkg::cnt_t'(1);
                    if (nd_reg == icrt_pkg::cnt_t'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_size_reg   <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
            state_reg        <= S_IDLE;
            neg_reg          <= 1'b0;
            nd_reg           <= '0;
        end
        else
        begin
            radix_size_reg   <= radix_size_next;
            symbols_low_reg  <= symbols_low_next;
            symbols_high_reg <= symbols_high_next;
            state_reg        <= state_next;
            neg_reg          <= neg_next;
            nd_reg           <= nd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stack_reg <= stack_next;
    end

    a_bad_alpha_drop : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !alpha_ok) |=> in_ready)
        else $error("value taken with an invalid alphabet was not dropped");

    a_last_ends_item : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("sequencer not idle after the last character transfer");

    a_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider result outside the division phase");

    a_stack_fill : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |->
            ((nd_reg != '0) && (nd_reg <= icrt_pkg::cnt_t'(icrt_pkg::VALUE_BITS))))
        else $error("digit count out of range while emitting");

endmodule
